[sv/rna_pkg.sv]
// Shared types, codes and widths of the rational number ALU.
package rna_pkg;

	localparam int unsigned DEF_WIDTH = 32;
	localparam int unsigned NUM_W     = 32;
	localparam int unsigned DEN_W     = 31;
	localparam int unsigned PROD_W    = 64;
	localparam int unsigned MAG_W     = 63;
	localparam int unsigned OPND_W    = 33;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_NEG = 3'd4,
		OP_CMP = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		CMP_EQ = 2'd0,
		CMP_LT = 2'd1,
		CMP_GT = 2'd2
	} cmp_t;

endpackage

[sv/rna_mul.sv]
// Signed multiplier with registered product, shared by all product terms.
module rna_mul (
	input  logic                                clk,
	input  logic signed [rna_pkg::OPND_W-1:0]   x,
	input  logic signed [rna_pkg::OPND_W-1:0]   y,
	output logic signed [rna_pkg::PROD_W-1:0]   p
);
	import rna_pkg::*;

	logic signed [2*OPND_W-1:0] prod;
	logic signed [PROD_W-1:0]   p_q;

	assign prod = x * y;

	always_ff @(posedge clk) begin
		p_q <= prod[PROD_W-1:0];
	end

	assign p = p_q;
endmodule

[sv/rna_red.sv]
// Reduction unit: binary GCD then two restoring divisions on one subtractor.
module rna_red (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rna_pkg::MAG_W-1:0]   num_in,
	input  logic [rna_pkg::MAG_W-1:0]   den_in,
	output logic                        done,
	output logic [rna_pkg::MAG_W-1:0]   num_out,
	output logic [rna_pkg::MAG_W-1:0]   den_out
);
	import rna_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAG_W);

	typedef enum logic [3:0] {
		R_IDLE = 4'b0001,
		R_GCD  = 4'b0010,
		R_DIVN = 4'b0100,
		R_DIVD = 4'b1000
	} red_state_t;

	red_state_t        state_q;
	logic [MAG_W-1:0]  u_q, v_q, g_q, nsave_q, dsave_q, rem_q, dvd_q, quo_q, qn_q;
	logic [CNT_W-1:0]  k_q, cnt_q;
	logic              done_q;
	logic [MAG_W+1:0]  sub_a, sub_b, diff;
	logic [MAG_W-1:0]  absd, gcd_val;
	logic [MAG_W:0]    rem_sh;

	assign rem_sh = {rem_q, dvd_q[MAG_W-1]};

	always_comb begin
		if (state_q == R_GCD) begin
			sub_a = {2'b00, u_q};
			sub_b = {2'b00, v_q};
		end else begin
			sub_a = {1'b0, rem_sh};
			sub_b = {2'b00, g_q};
		end
	end

	assign diff    = sub_a - sub_b;
	assign absd    = diff[MAG_W+1] ? MAG_W'(sub_b - sub_a) : diff[MAG_W-1:0];
	assign gcd_val = (u_q | v_q) << k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				R_IDLE: begin
					if (start) state_q <= R_GCD;
				end
				R_GCD: begin
					if (u_q == '0 || v_q == '0) state_q <= R_DIVN;
				end
				R_DIVN: begin
					if (cnt_q == CNT_W'(MAG_W-1)) state_q <= R_DIVD;
				end
				R_DIVD: begin
					if (cnt_q == CNT_W'(MAG_W-1)) begin
						state_q <= R_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE: begin
				u_q     <= num_in;
				v_q     <= den_in;
				nsave_q <= num_in;
				dsave_q <= den_in;
				k_q     <= '0;
			end
			R_GCD: begin
				if (u_q == '0 || v_q == '0) begin
					g_q   <= gcd_val;
					rem_q <= '0;
					dvd_q <= nsave_q;
					cnt_q <= '0;
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + CNT_W'(1);
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (!diff[MAG_W+1]) begin
					u_q <= absd >> 1;
				end else begin
					v_q <= absd >> 1;
				end
			end
			R_DIVN, R_DIVD: begin
				quo_q <= {quo_q[MAG_W-2:0], ~diff[MAG_W+1]};
				if (cnt_q == CNT_W'(MAG_W-1) && state_q == R_DIVN) begin
					qn_q  <= {quo_q[MAG_W-2:0], ~diff[MAG_W+1]};
					rem_q <= '0;
					dvd_q <= dsave_q;
					cnt_q <= '0;
				end else begin
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q + CNT_W'(1);
					if (!diff[MAG_W+1]) rem_q <= diff[MAG_W-1:0];
					else                rem_q <= rem_sh[MAG_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign done    = done_q;
	assign num_out = qn_q;
	assign den_out = quo_q;
endmodule

[sv/rational_number_alu.sv]
// Rational number ALU top level: request capture, sequencer and result register.
// Each request forms three products on one multiplier, then runs the reduction
// unit: a binary GCD plus two 63-bit restoring divisions on one shared
// subtractor; zero results, compare and error requests skip the reduction.
// in_stall is high from acceptance until the result is loaded into the output register.
module rational_number_alu #(
	parameter int unsigned WIDTH = rna_pkg::DEF_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        op,
	input  logic signed [rna_pkg::NUM_W-1:0]  a_num,
	input  logic [rna_pkg::DEN_W-1:0]         a_den,
	input  logic signed [rna_pkg::NUM_W-1:0]  b_num,
	input  logic [rna_pkg::DEN_W-1:0]         b_den,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [rna_pkg::NUM_W-1:0]  res_num,
	output logic [rna_pkg::DEN_W-1:0]         res_den,
	output logic [1:0]                        cmp_result,
	output logic                              div_zero,
	output logic                              overflow
);
	import rna_pkg::*;

	localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (WIDTH-1);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_MA   = 9'b000000010,
		S_MB   = 9'b000000100,
		S_MC   = 9'b000001000,
		S_MD   = 9'b000010000,
		S_ABS  = 9'b000100000,
		S_ST   = 9'b001000000,
		S_RED  = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	state_t                   state_q;
	logic [2:0]               op_q;
	logic signed [NUM_W-1:0]  an_q, bn_q;
	logic [DEN_W-1:0]         ad_q, bd_q;
	logic signed [PROD_W-1:0] num_q, den_q, p;
	logic signed [OPND_W-1:0] mx, my, san, sbn, sad, sbd;
	logic [MAG_W-1:0]         mag_q, udn_q, red_num, red_den;
	logic                     neg_q, red_done, red_start, ovf;
	logic signed [NUM_W-1:0]  on_q;
	logic [DEN_W-1:0]         od_q;
	logic [1:0]               rc_q, oc_q;
	logic                     rz_q, oz_q, oo_q, out_valid_q, load;

	assign san = OPND_W'(an_q);
	assign sbn = OPND_W'(bn_q);
	assign sad = OPND_W'({1'b0, ad_q});
	assign sbd = OPND_W'({1'b0, bd_q});

	always_comb begin
		mx = '0;
		my = '0;
		case (state_q)
			S_MA: begin
				mx = san;
				case (op_q)
					OP_MUL:  my = sbn;
					OP_NEG:  my = -OPND_W'(1);
					default: my = sbd;
				endcase
			end
			S_MB: begin
				if (op_q inside {OP_ADD, OP_SUB, OP_CMP}) begin
					mx = sbn;
					my = sad;
				end
			end
			S_MC: begin
				mx = sad;
				case (op_q)
					OP_DIV:  my = sbn;
					OP_NEG:  my = OPND_W'(1);
					default: my = sbd;
				endcase
			end
			default: ;
		endcase
	end

	rna_mul u_mul (.clk(clk), .x(mx), .y(my), .p(p));

	assign red_start = (state_q == S_ST) && (mag_q != '0);

	rna_red u_red (
		.clk(clk), .arst_n(arst_n), .start(red_start),
		.num_in(mag_q), .den_in(udn_q),
		.done(red_done), .num_out(red_num), .den_out(red_den)
	);

	assign ovf  = (udn_q > LIM - MAG_W'(1)) ||
	              (neg_q ? (mag_q > LIM) : (mag_q > LIM - MAG_W'(1)));
	assign load = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (op > OP_CMP || a_den == '0 || (op != OP_NEG && b_den == '0) ||
						    (op == OP_DIV && b_num == '0))
							state_q <= S_FIN;
						else
							state_q <= S_MA;
					end
				end
				S_MA:  state_q <= S_MB;
				S_MB:  state_q <= S_MC;
				S_MC:  state_q <= S_MD;
				S_MD:  state_q <= S_ABS;
				S_ABS: state_q <= (op_q == OP_CMP) ? S_FIN : S_ST;
				S_ST:  state_q <= (mag_q == '0) ? S_FIN : S_RED;
				S_RED: begin
					if (red_done) state_q <= S_FIN;
				end
				S_FIN: begin
					if (load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q <= op;
				an_q <= a_num;
				ad_q <= a_den;
				bn_q <= b_num;
				bd_q <= b_den;
				rc_q <= CMP_EQ;
				rz_q <= (op <= OP_CMP) && (a_den == '0 || (op != OP_NEG && b_den == '0) ||
				        (op == OP_DIV && b_num == '0));
			end
			S_MB: num_q <= p;
			S_MC: num_q <= (op_q == OP_ADD) ? num_q + p : num_q - p;
			S_MD: den_q <= p;
			S_ABS: begin
				neg_q <= num_q[PROD_W-1] ^ den_q[PROD_W-1];
				mag_q <= num_q[PROD_W-1] ? MAG_W'(-num_q) : MAG_W'(num_q);
				udn_q <= den_q[PROD_W-1] ? MAG_W'(-den_q) : MAG_W'(den_q);
				if (op_q == OP_CMP) begin
					if (num_q == '0)             rc_q <= CMP_EQ;
					else if (num_q[PROD_W-1])    rc_q <= CMP_LT;
					else                         rc_q <= CMP_GT;
				end
			end
			S_ST: begin
				if (mag_q == '0) begin
					udn_q <= MAG_W'(1);
					neg_q <= 1'b0;
				end
			end
			S_RED: begin
				if (red_done) begin
					mag_q <= red_num;
					udn_q <= red_den;
				end
			end
			default: ;
		endcase
		if (load) begin
			on_q <= (op_q != OP_CMP && !rz_q && op_q <= OP_CMP && !ovf) ?
			        (neg_q ? NUM_W'(-mag_q) : NUM_W'(mag_q)) : '0;
			od_q <= (op_q != OP_CMP && !rz_q && op_q <= OP_CMP && !ovf) ?
			        udn_q[DEN_W-1:0] : DEN_W'(1);
			oc_q <= rc_q;
			oz_q <= rz_q;
			oo_q <= (op_q != OP_CMP && !rz_q && op_q <= OP_CMP) ? ovf : 1'b0;
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign res_num    = on_q;
	assign res_den    = od_q;
	assign cmp_result = oc_q;
	assign div_zero   = oz_q;
	assign overflow   = oo_q;
endmodule

[sv/rna_chk.sv]
// Port checker for the rational number ALU, bound to the top level.
module rna_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] res_num,
	input logic [30:0] res_den,
	input logic [1:0]  cmp_result,
	input logic        div_zero,
	input logic        overflow
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(res_num) && $stable(res_den))
		else $error("result changed while stalled");

	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> res_den != 31'd0)
		else $error("zero denominator");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (div_zero || overflow) |-> res_num == 32'd0 && res_den == 31'd1)
		else $error("error result not 0/1");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_num == 32'd0 |-> res_den == 31'd1)
		else $error("zero not given as 0/1");

	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cmp_result != 2'd3 && !(div_zero && overflow))
		else $error("bad compare code or flags");
endmodule

bind rational_number_alu rna_chk u_rna_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.res_num(res_num), .res_den(res_den), .cmp_result(cmp_result),
	.div_zero(div_zero), .overflow(overflow)
);
